// ===== rtl/ctaphid_request_deframer_top_macros.svh =====
// ----------------------------------------------------------------------------
// CTAPHID request deframer assertion macros
// Concurrent checks sampled on the clock, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CTAPHID_REQUEST_DEFRAMER_TOP_MACROS_SVH
`define CTAPHID_REQUEST_DEFRAMER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define CRD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CRD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Expression never holds.
`define CRD_ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`else

`define CRD_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define CRD_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`define CRD_ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

// ===== rtl/crd_pkg.sv =====
// ----------------------------------------------------------------------------
// CTAPHID request deframer package
// Payload types, result and error codes, controller state and the command
// and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package crd_pkg;

  localparam int LEN_W = 13;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET   = 13'd1024;
  localparam logic [31:0]      BROADCAST_CHAN  = 32'hFFFF_FFFF;
  localparam logic [6:0]       CMD_INIT        = 7'h06;
  localparam int               INIT_HDR        = 7;
  localparam int               CONT_HDR        = 5;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_START   = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  // transport error codes
  localparam logic [1:0] ERR_SEQ  = 2'd0;
  localparam logic [1:0] ERR_LEN  = 2'd1;
  localparam logic [1:0] ERR_CHAN = 2'd2;

  typedef struct packed {
    logic [7:0] report_byte;
    logic       report_last;
  } crd_in_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data_byte;
    logic [31:0]      chan_id;
    logic [6:0]       command;
    logic [LEN_W-1:0] message_length;
    logic [1:0]       error_code;
    logic             last;
  } crd_out_t;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_DECODE,
    ST_ERROR,
    ST_START,
    ST_PAYLOAD,
    ST_DONE
  } crd_state_t;

  // controller -> datapath
  typedef struct packed {
    logic       accept;
    logic       load_init;
    logic       cont_step;
    logic       err_set;
    logic [1:0] err_code;
    logic       drop;
    logic       emit;
    logic [1:0] emit_kind;
    logic       emit_last;
    logic       pay_step;
  } crd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic whole;
    logic hdr_init;
    logic chan_bcast;
    logic chan_match;
    logic req_active;
    logic seq_ok;
    logic len_over;
    logic cmd_init;
    logic remain_zero;
    logic remain_one;
    logic will_finish;
    logic out_free;
  } crd_sts_t;

endpackage

// ===== rtl/crd_ctrl.sv =====
// ----------------------------------------------------------------------------
// CTAPHID request deframer controller
// Sequences report collection, header decode and result emission.
// ----------------------------------------------------------------------------
module crd_ctrl import crd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       report_last,
  input  crd_sts_t   sts,
  output logic       in_stall,
  output crd_cmd_t   cmd
);

  crd_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != ST_COLLECT);
    case (state)
      ST_COLLECT: begin
        cmd.accept = in_valid;
        if (in_valid && report_last && sts.whole) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (!sts.hdr_init) begin
          if (!sts.req_active || !sts.chan_match) begin
            // stray continuation: keep the request
            if (!sts.chan_bcast) begin
              cmd.err_set  = 1'b1;
              cmd.err_code = ERR_SEQ;
              state_next   = ST_ERROR;
            end else begin
              state_next = ST_COLLECT;
            end
          end else if (!sts.seq_ok) begin
            cmd.err_set  = 1'b1;
            cmd.err_code = ERR_SEQ;
            cmd.drop     = 1'b1;
            state_next   = ST_ERROR;
          end else begin
            cmd.cont_step = 1'b1;
            state_next    = ST_PAYLOAD;
          end
        end else if (sts.len_over) begin
          cmd.err_set  = 1'b1;
          cmd.err_code = ERR_LEN;
          cmd.drop     = 1'b1;
          state_next   = ST_ERROR;
        end else if (sts.chan_bcast && !sts.cmd_init) begin
          cmd.err_set  = 1'b1;
          cmd.err_code = ERR_CHAN;
          cmd.drop     = 1'b1;
          state_next   = ST_ERROR;
        end else begin
          cmd.load_init = 1'b1;
          state_next    = ST_START;
        end
      end
      ST_ERROR: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_ERROR;
          cmd.emit_last = 1'b1;
          state_next    = ST_COLLECT;
        end
      end
      ST_START: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_START;
          cmd.emit_last = sts.remain_zero && !sts.will_finish;
          if (!sts.remain_zero) begin
            state_next = ST_PAYLOAD;
          end else if (sts.will_finish) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_COLLECT;
          end
        end
      end
      ST_PAYLOAD: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_PAYLOAD;
          cmd.emit_last = sts.remain_one && !sts.will_finish;
          cmd.pay_step  = 1'b1;
          if (sts.remain_one) begin
            state_next = sts.will_finish ? ST_DONE : ST_COLLECT;
          end
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_DONE;
          cmd.emit_last = 1'b1;
          cmd.drop      = 1'b1;
          state_next    = ST_COLLECT;
        end
      end
      default: begin
        state_next = ST_COLLECT;
      end
    endcase
  end

endmodule

// ===== rtl/crd_datapath.sv =====
// ----------------------------------------------------------------------------
// CTAPHID request deframer datapath
// Report store, header capture, request registers and the result register.
// ----------------------------------------------------------------------------
module crd_datapath import crd_pkg::*; #(
  parameter int PACKET_BYTES = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  crd_in_t          in_item,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  input  crd_cmd_t         cmd,
  input  logic             out_stall,
  output crd_sts_t         sts,
  output logic             out_valid,
  output crd_out_t         out_item
);

  localparam int AW    = $clog2(PACKET_BYTES);
  localparam int DEPTH = 1 << AW;
  localparam int CW    = $clog2(PACKET_BYTES + 2);
  localparam int RW    = $clog2(PACKET_BYTES - CONT_HDR + 1);

  localparam logic [CW-1:0]    BC_FULL    = CW'(PACKET_BYTES);
  localparam logic [CW-1:0]    BC_LASTPOS = CW'(PACKET_BYTES - 1);
  localparam logic [CW-1:0]    BC_OVER    = CW'(PACKET_BYTES + 1);
  localparam logic [CW-1:0]    BC_HDR     = CW'(INIT_HDR);
  localparam logic [LEN_W-1:0] INIT_ROOM  = LEN_W'(PACKET_BYTES - INIT_HDR);
  localparam logic [LEN_W-1:0] CONT_ROOM  = LEN_W'(PACKET_BYTES - CONT_HDR);

  logic [7:0]       mem [DEPTH];
  logic [7:0]       rdata;
  logic [CW-1:0]    byte_count;
  logic [7:0]       hdr_b [INIT_HDR];
  logic [LEN_W-1:0] max_len;

  logic             req_active;
  logic [31:0]      req_chan;
  logic [6:0]       req_cmd;
  logic [LEN_W-1:0] req_total;
  logic [LEN_W-1:0] req_received;
  logic [7:0]       exp_seq;

  logic [AW-1:0]    ptr, ptr_next;
  logic [RW-1:0]    remain;
  logic             will_finish;
  logic [1:0]       err_code;

  logic [31:0]      hdr_chan;
  logic [15:0]      hdr_len;
  logic [LEN_W-1:0] init_len;
  logic [LEN_W-1:0] cont_left;
  logic [LEN_W-1:0] init_chunk;
  logic [LEN_W-1:0] cont_chunk;
  logic             out_free;

  assign hdr_chan   = {hdr_b[0], hdr_b[1], hdr_b[2], hdr_b[3]};
  assign hdr_len    = {hdr_b[5], hdr_b[6]};
  assign init_len   = hdr_len[LEN_W-1:0];
  assign cont_left  = req_total - req_received;
  assign init_chunk = (init_len < INIT_ROOM) ? init_len : INIT_ROOM;
  assign cont_chunk = (cont_left < CONT_ROOM) ? cont_left : CONT_ROOM;
  assign out_free   = !out_valid || !out_stall;

  // store write and capture of the header bytes
  always_ff @(posedge clk) begin
    if (cmd.accept && (byte_count < BC_FULL)) begin
      mem[byte_count[AW-1:0]] <= in_item.report_byte;
    end
    if (cmd.accept && (byte_count < BC_HDR)) begin
      hdr_b[byte_count[2:0]] <= in_item.report_byte;
    end
  end

  // read port tracks the next pointer, so rdata always holds mem[ptr]
  always_comb begin
    ptr_next = ptr;
    if (cmd.load_init) begin
      ptr_next = AW'(INIT_HDR);
    end else if (cmd.cont_step) begin
      ptr_next = AW'(CONT_HDR);
    end else if (cmd.pay_step) begin
      ptr_next = ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[ptr_next];
    ptr   <= ptr_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (cmd.accept) begin
      if (in_item.report_last) begin
        byte_count <= '0;
      end else if (byte_count < BC_FULL) begin
        byte_count <= byte_count + 1'b1;
      end else begin
        byte_count <= BC_OVER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_len <= cfg_wdata;
    end
  end

  // request registers
  always_ff @(posedge clk) begin
    if (rst) begin
      req_active   <= 1'b0;
      req_chan     <= '0;
      req_cmd      <= '0;
      req_total    <= '0;
      req_received <= '0;
      exp_seq      <= '0;
    end else if (cmd.drop) begin
      req_active   <= 1'b0;
      req_chan     <= '0;
      req_cmd      <= '0;
      req_total    <= '0;
      req_received <= '0;
      exp_seq      <= '0;
    end else if (cmd.load_init) begin
      req_active   <= 1'b1;
      req_chan     <= hdr_chan;
      req_cmd      <= hdr_b[4][6:0];
      req_total    <= init_len;
      req_received <= '0;
      exp_seq      <= '0;
    end else begin
      if (cmd.cont_step) begin
        exp_seq <= exp_seq + 1'b1;
      end
      if (cmd.pay_step) begin
        req_received <= req_received + 1'b1;
      end
    end
  end

  // per-report emission counters
  always_ff @(posedge clk) begin
    if (rst) begin
      remain      <= '0;
      will_finish <= 1'b0;
    end else if (cmd.load_init) begin
      remain      <= RW'(init_chunk);
      will_finish <= (init_len <= INIT_ROOM);
    end else if (cmd.cont_step) begin
      remain      <= RW'(cont_chunk);
      will_finish <= (cont_left <= CONT_ROOM);
    end else if (cmd.pay_step) begin
      remain <= remain - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.err_set) begin
      err_code <= cmd.err_code;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item.kind <= cmd.emit_kind;
      out_item.last <= cmd.emit_last;
      if (cmd.emit_kind == KIND_ERROR) begin
        out_item.data_byte      <= '0;
        out_item.chan_id        <= hdr_chan;
        out_item.command        <= '0;
        out_item.message_length <= '0;
        out_item.error_code     <= err_code;
      end else begin
        out_item.data_byte      <= (cmd.emit_kind == KIND_PAYLOAD) ? rdata : 8'h00;
        out_item.chan_id        <= req_chan;
        out_item.command        <= req_cmd;
        out_item.message_length <= req_total;
        out_item.error_code     <= '0;
      end
    end
  end

  always_comb begin
    sts.whole       = (byte_count == BC_LASTPOS);
    sts.hdr_init    = hdr_b[4][7];
    sts.chan_bcast  = (hdr_chan == BROADCAST_CHAN);
    sts.chan_match  = (hdr_chan == req_chan);
    sts.req_active  = req_active;
    sts.seq_ok      = (hdr_b[4] == exp_seq);
    sts.len_over    = (hdr_len > {{(16-LEN_W){1'b0}}, max_len});
    sts.cmd_init    = (hdr_b[4][6:0] == CMD_INIT);
    sts.remain_zero = (remain == '0);
    sts.remain_one  = (remain == RW'(1));
    sts.will_finish = will_finish;
    sts.out_free    = out_free;
  end

endmodule

// ===== rtl/ctaphid_request_deframer_top.sv =====
// ----------------------------------------------------------------------------
// CTAPHID request deframer: one report byte per cycle in while collecting;
// no byte is taken while a report is decoded and its results are emitted
// through the single result register.
// Synchronous reset clears the controller, counters and request, and loads the
// length limit with 1024; the report store holds no reset value.
// ----------------------------------------------------------------------------
`include "ctaphid_request_deframer_top_macros.svh"

module ctaphid_request_deframer_top import crd_pkg::*; #(
  parameter int PACKET_BYTES = 64
) (
  input  logic             clk,
  input  logic             rst,
  // report byte channel
  input  logic             in_valid,
  output logic             in_stall,
  input  crd_in_t          in_item,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output crd_out_t         out_item,
  // length limit register
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata
);

  // The controller takes report bytes only while collecting. When the final
  // byte of a report of exactly PACKET_BYTES bytes is transferred, it stops
  // taking bytes, decodes the captured header, then emits the start of an init
  // report, the payload bytes and the completion of a whole message, or a single
  // transport error, one result per cycle whenever the result register is free.
  crd_cmd_t cmd;
  crd_sts_t sts;

  crd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .report_last (in_item.report_last),
    .sts         (sts),
    .in_stall    (in_stall),
    .cmd         (cmd)
  );

  // The datapath holds the report store with a registered read port that
  // follows the payload pointer, the request registers, the length limit and
  // the result register that parts the controller from the result stall.
  crd_datapath #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .out_stall (out_stall),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Never overwrite a result that is still waiting for its transfer.
  `CRD_ASSERT_NEVER(a_emit_when_busy, clk, rst, cmd.emit && out_valid && out_stall,
    "result register overwritten while stalled")

  // Errors and completions always close the results of a report.
  `CRD_ASSERT_IMP(a_err_last, clk, rst,
    out_valid && ((out_item.kind == KIND_ERROR) || (out_item.kind == KIND_DONE)),
    out_item.last, "error or completion without last mark")

  // A message is opened only when its length passed the limit check.
  `CRD_ASSERT_IMP(a_init_len, clk, rst, cmd.load_init, !sts.len_over,
    "message opened with length over limit")

  // A continuation is followed only on the active request's channel.
  `CRD_ASSERT_IMP(a_cont_match, clk, rst, cmd.cont_step,
    sts.req_active && sts.chan_match && sts.seq_ok, "continuation taken without match")

  // No byte is taken while a report is being worked on.
  `CRD_ASSERT_NXT(a_decode_stall, clk, rst,
    cmd.accept && in_item.report_last && sts.whole, in_stall,
    "report byte taken during decode")

endmodule
